// ===== hdl/perspective_warp_address_defines.svh =====
// Assertion macros shared by the perspective warp address checker.
// No dependencies; pulled in by `include where assertions are written.
`ifndef PERSPECTIVE_WARP_ADDRESS_DEFINES_SVH
`define PERSPECTIVE_WARP_ADDRESS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PWA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pwa_pkg.sv =====
// Package for the perspective warp address generator: widths, limits,
// register indexes and the divider lane word. No dependencies.
`timescale 1ns / 1ps

package pwa_pkg;

  localparam int COEF_W  = 48;
  localparam int NCOEF   = 8;
  localparam int PROD_W  = 59;
  localparam int SUM_W   = 60;
  localparam int MAG_W   = 60;
  // quotient bits resolved by the cell row
  localparam int QUO_W   = 16;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 10;
  localparam int RAST_W  = 15;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int IDX_W   = 3;

  localparam int OUT_WIDTH  = 1024;
  localparam int OUT_HEIGHT = 768;
  localparam int SRC_WIDTH  = 4096;
  localparam int SRC_HEIGHT = 4096;

  localparam logic signed [COEF_W-1:0] ONE_COEF = 48'sh0001_0000_0000;
  localparam logic signed [SUM_W-1:0]  ONE_SUM  = 60'sh0_0001_0000_0000;

  localparam logic [IDX_W-1:0] REG_COEF_00 = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_01 = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_02 = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_10 = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_11 = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_12 = 3'd5;
  localparam logic [IDX_W-1:0] REG_COEF_20 = 3'd6;
  localparam logic [IDX_W-1:0] REG_COEF_21 = 3'd7;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic             xneg;
    logic             yneg;
    logic [MAG_W-1:0] rx;
    logic [MAG_W-1:0] ry;
    logic [MAG_W-1:0] den;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
  } pwa_lane_t;

endpackage

// ===== hdl/pwa_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit of X/W and Y/W.
// Depends on pwa_pkg.
`timescale 1ns / 1ps

module pwa_div_cell import pwa_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  pwa_lane_t lane_i,
  output pwa_lane_t lane_o
);

  localparam int CW = MAG_W + SHIFT + 1;

  logic [CW-1:0] dvs, dx, dy;
  logic          gx, gy;
  pwa_lane_t     lane_d, lane_q;

  assign dvs = CW'(lane_i.den) << SHIFT;
  assign dx  = CW'(lane_i.rx) - dvs;
  assign dy  = CW'(lane_i.ry) - dvs;
  // no borrow means the shifted divisor fits
  assign gx  = !dx[CW-1];
  assign gy  = !dy[CW-1];

  always_comb begin
    lane_d    = lane_i;
    lane_d.qx = {lane_i.qx[QUO_W-2:0], gx};
    lane_d.qy = {lane_i.qy[QUO_W-2:0], gy};
    if (gx) begin
      lane_d.rx = dx[MAG_W-1:0];
    end
    if (gy) begin
      lane_d.ry = dy[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== hdl/perspective_warp_address.sv =====
// Perspective warp address generator. One output pixel (column, row) goes in
// per clock and one source address comes out per clock, unless stalled: two
// stages form the products and projective sums, one takes magnitudes, a row
// of 16 division cells resolves one quotient bit each for X/W and Y/W, and
// the output register rounds to nearest even and checks bounds. The whole
// pipeline holds while a finished word waits under out_stall_i.
// Depends on pwa_pkg and pwa_div_cell.
`timescale 1ns / 1ps

module perspective_warp_address import pwa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PIX_W-1:0]    out_col_i,
  input  logic [PIX_W-1:0]    out_row_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [COORD_W-1:0]  src_col_o,
  output logic [COORD_W-1:0]  src_row_o,
  output logic                in_bounds_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic signed [COEF_W-1:0] coef_q [NCOEF];
  logic [IDX_W-1:0]         idx;
  logic                     adv;

  logic                     s1_vld_q, s1_rok_q;
  logic signed [PROD_W-1:0] p00_q, p01_q, p10_q, p11_q, p20_q, p21_q;
  logic signed [COEF_W-1:0] c02_q, c12_q;
  logic                     s1_rok_d;

  logic                     s2_vld_q, s2_rok_q;
  logic signed [SUM_W-1:0]  sx_q, sy_q, sw_q;

  pwa_lane_t                lane [QUO_W+1];
  pwa_lane_t                lane0_d;

  pwa_lane_t                fin;
  logic                     incx, incy, okx, oky, ok;
  logic [QUO_W:0]           qrx, qry;

  logic                     out_valid_q, in_bounds_q;
  logic [COORD_W-1:0]       src_col_q, src_row_q;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= (i == int'(REG_COEF_00) || i == int'(REG_COEF_11)) ? ONE_COEF : '0;
      end
    end else if (psel && penable && pwrite) begin
      coef_q[idx] <= pwdata[COEF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_COEF_00, REG_COEF_01, REG_COEF_02, REG_COEF_10,
      REG_COEF_11, REG_COEF_12, REG_COEF_20, REG_COEF_21: begin
        prdata = {{(DATA_W-COEF_W){1'b0}}, coef_q[idx]};
      end
      default: prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: products ----------------
  assign s1_rok_d = (RAST_W'(out_col_i) < RAST_W'(OUT_WIDTH)) &&
                    (RAST_W'(out_row_i) < RAST_W'(OUT_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_rok_q <= s1_rok_d;
      p00_q <= PROD_W'(coef_q[REG_COEF_00]) * PROD_W'($signed({1'b0, out_col_i}));
      p01_q <= PROD_W'(coef_q[REG_COEF_01]) * PROD_W'($signed({1'b0, out_row_i}));
      p10_q <= PROD_W'(coef_q[REG_COEF_10]) * PROD_W'($signed({1'b0, out_col_i}));
      p11_q <= PROD_W'(coef_q[REG_COEF_11]) * PROD_W'($signed({1'b0, out_row_i}));
      p20_q <= PROD_W'(coef_q[REG_COEF_20]) * PROD_W'($signed({1'b0, out_col_i}));
      p21_q <= PROD_W'(coef_q[REG_COEF_21]) * PROD_W'($signed({1'b0, out_row_i}));
      c02_q <= coef_q[REG_COEF_02];
      c12_q <= coef_q[REG_COEF_12];
    end
  end

  // ---------------- stage 2: projective sums ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_rok_q <= s1_rok_q;
      sx_q <= SUM_W'(p00_q) + SUM_W'(p01_q) + SUM_W'(c02_q);
      sy_q <= SUM_W'(p10_q) + SUM_W'(p11_q) + SUM_W'(c12_q);
      sw_q <= SUM_W'(p20_q) + SUM_W'(p21_q) + ONE_SUM;
    end
  end

  // ---------------- stage 3: magnitudes into the cell row ----------------
  always_comb begin
    lane0_d.vld  = s2_vld_q;
    lane0_d.ok   = s2_rok_q && (sw_q != '0);
    lane0_d.xneg = sx_q[SUM_W-1] ^ sw_q[SUM_W-1];
    lane0_d.yneg = sy_q[SUM_W-1] ^ sw_q[SUM_W-1];
    lane0_d.rx   = sx_q[SUM_W-1] ? MAG_W'(-sx_q) : MAG_W'(sx_q);
    lane0_d.ry   = sy_q[SUM_W-1] ? MAG_W'(-sy_q) : MAG_W'(sy_q);
    lane0_d.den  = sw_q[SUM_W-1] ? MAG_W'(-sw_q) : MAG_W'(sw_q);
    lane0_d.qx   = '0;
    lane0_d.qy   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane[0] <= '0;
    end else if (adv) begin
      lane[0] <= lane0_d;
    end
  end

  // ---------------- division cells, MSB first ----------------
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    pwa_div_cell #(
      .SHIFT (QUO_W - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .lane_i (lane[k]),
      .lane_o (lane[k+1])
    );
  end

  // ---------------- round, bounds, output word ----------------
  assign fin  = lane[QUO_W];
  // ties go to the even quotient
  assign incx = ({fin.rx, 1'b0} > {1'b0, fin.den}) ||
                (({fin.rx, 1'b0} == {1'b0, fin.den}) && fin.qx[0]);
  assign incy = ({fin.ry, 1'b0} > {1'b0, fin.den}) ||
                (({fin.ry, 1'b0} == {1'b0, fin.den}) && fin.qy[0]);
  assign qrx  = (QUO_W+1)'(fin.qx) + (QUO_W+1)'(incx);
  assign qry  = (QUO_W+1)'(fin.qy) + (QUO_W+1)'(incy);
  // a negative quotient is only allowed when it rounds to zero
  assign okx  = !(fin.xneg && (qrx != '0)) && (qrx < (QUO_W+1)'(SRC_WIDTH));
  assign oky  = !(fin.yneg && (qry != '0)) && (qry < (QUO_W+1)'(SRC_HEIGHT));
  assign ok   = fin.ok && okx && oky;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_bounds_q <= ok;
      src_col_q   <= ok ? qrx[COORD_W-1:0] : '0;
      src_row_q   <= ok ? qry[COORD_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_bounds_o = in_bounds_q;
  assign src_col_o   = src_col_q;
  assign src_row_o   = src_row_q;

endmodule

// ===== hdl/pwa_checker.sv =====
// Port-level checks for the perspective warp address generator, bound in.
// Depends on pwa_pkg and perspective_warp_address_defines.svh.
`timescale 1ns / 1ps
`include "perspective_warp_address_defines.svh"

module pwa_checker import pwa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [COORD_W-1:0] src_col_o,
  input logic [COORD_W-1:0] src_row_o,
  input logic               in_bounds_o
);

  // a black pixel carries a zero address
  `PWA_ASSERT_NOW(a_black_zero, out_valid_o && !in_bounds_o, (src_col_o == '0) && (src_row_o == '0), "out-of-bounds word with nonzero address")

  // input stalls exactly when a finished word is held back
  `PWA_ASSERT_NOW(a_stall_link, 1'b1, in_stall_o == (out_valid_o && out_stall_i), "input stall does not follow output backpressure")

  // held word stays put
  `PWA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(src_col_o) && $stable(src_row_o) && $stable(in_bounds_o), "stalled output word changed")

endmodule

bind perspective_warp_address pwa_checker u_pwa_checker (.*);
